FILE: rtl/core/ccb_pkg.sv
package ccb_pkg;

    // Image store geometry.
    localparam int MAX_WIDTH  = 512;
    localparam int MAX_HEIGHT = 512;
    localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT;

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);
    localparam int IDX_W = $clog2(DEPTH);
    localparam int POS_W = IDX_W + 1;
    localparam int DIM_W = $clog2(MAX_WIDTH + 1);
    localparam int HGT_W = $clog2(MAX_HEIGHT + 1);

    // Configuration port.
    localparam int CFG_W     = 10;
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'd1;

    // Operation codes of an input item.
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_FETCH = 1'b1;

    typedef struct packed {
        logic        op;
        logic [17:0] pixel_index;
        logic        pixel_set;
    } in_item_t;

    typedef struct packed {
        logic        found;
        logic [8:0]  min_col;
        logic [8:0]  min_row;
        logic [8:0]  max_col;
        logic [8:0]  max_row;
        logic [18:0] pixel_count;
    } out_item_t;

    // One entry of the flood-fill stack: pixel coordinates.
    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
    } stk_entry_t;

    // Direction of one of the eight neighbours.
    typedef struct packed {
        logic up;
        logic down;
        logic left;
        logic right;
    } nb_dir_t;

    function automatic nb_dir_t nb_dir(input logic [2:0] code);
        nb_dir_t d;
        d = '0;
        case (code)
            3'd0: begin d.up = 1'b1;   d.left  = 1'b1; end
            3'd1: begin d.up = 1'b1;                   end
            3'd2: begin d.up = 1'b1;   d.right = 1'b1; end
            3'd3: begin                d.left  = 1'b1; end
            3'd4: begin                d.right = 1'b1; end
            3'd5: begin d.down = 1'b1; d.left  = 1'b1; end
            3'd6: begin d.down = 1'b1;                 end
            default: begin d.down = 1'b1; d.right = 1'b1; end
        endcase
        return d;
    endfunction

endpackage

FILE: rtl/core/connected_component_boxes.sv
// Channel | Direction | Handshake            | Payload
// in      | input     | in_valid / in_ready  | in_data  (op, pixel_index, pixel_set)
// out     | output    | out_valid / out_ready| out_data (found, box, pixel_count)
// cfg     | input     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// A write item goes into the pixel memory when accepted. A fetch reads, then checks, each
// scanned pixel; per component pixel it pops the stack, then reads and checks each of the
// eight neighbours inside the image: the single read port of the pixel memory sets this.
// After a geometry change the first fetch first runs a serial divider. After reset a
// clearing pass over the whole pixel memory takes no input items. in_ready stays high while
// one result waits on a stalled output; a second finished result holds in_ready low.
module connected_component_boxes
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  ccb_pkg::in_item_t             in_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output ccb_pkg::out_item_t            out_data,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [ccb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ccb_pkg::CFG_W-1:0]     cfg_data
);

    localparam int COL_W = ccb_pkg::COL_W;
    localparam int ROW_W = ccb_pkg::ROW_W;
    localparam int IDX_W = ccb_pkg::IDX_W;
    localparam int POS_W = ccb_pkg::POS_W;
    localparam int DIM_W = ccb_pkg::DIM_W;
    localparam int HGT_W = ccb_pkg::HGT_W;
    localparam int DEPTH = ccb_pkg::DEPTH;
    localparam int DCNT_W = $clog2(POS_W);
    localparam int CFG_W_L = ccb_pkg::CFG_W;

    localparam logic [3:0] ST_CLEAR = 4'd0;
    localparam logic [3:0] ST_IDLE  = 4'd1;
    localparam logic [3:0] ST_DIV   = 4'd2;
    localparam logic [3:0] ST_SRD   = 4'd3;
    localparam logic [3:0] ST_SCHK  = 4'd4;
    localparam logic [3:0] ST_POP   = 4'd5;
    localparam logic [3:0] ST_PIX   = 4'd6;
    localparam logic [3:0] ST_NRD   = 4'd7;
    localparam logic [3:0] ST_NCHK  = 4'd8;
    localparam logic [3:0] ST_DONE  = 4'd9;

    // Pixel memory: bit 1 is the mask, bit 0 the visited mark.
    logic [1:0]              pix_mem [DEPTH];
    logic                    pm_we;
    logic [IDX_W-1:0]        pm_waddr;
    logic [1:0]              pm_wdata;
    logic [IDX_W-1:0]        pm_raddr;
    logic [1:0]              pm_q;

    // Flood-fill stack memory.
    ccb_pkg::stk_entry_t     stk_mem [DEPTH];
    logic                    stk_we;
    logic [IDX_W-1:0]        stk_waddr;
    ccb_pkg::stk_entry_t     stk_wdata;
    logic [IDX_W-1:0]        stk_raddr;
    ccb_pkg::stk_entry_t     stk_q;

    logic [3:0]              state_reg, state_next;
    logic [CFG_W_L-1:0]      width_reg, height_reg;
    logic                    dirty_reg, dirty_next;
    logic [POS_W-1:0]        total_reg;
    logic [IDX_W-1:0]        clr_reg, clr_next;

    logic [POS_W-1:0]        scan_pos_reg, scan_pos_next;
    logic [COL_W-1:0]        scan_col_reg, scan_col_next;
    logic [ROW_W-1:0]        scan_row_reg, scan_row_next;

    logic [POS_W-1:0]        dvd_reg, dvd_next;
    logic [DIM_W-1:0]        rem_reg, rem_next;
    logic [POS_W-1:0]        quo_reg, quo_next;
    logic [DCNT_W-1:0]       dcnt_reg, dcnt_next;

    logic [POS_W-1:0]        lvl_reg, lvl_next;
    logic [COL_W-1:0]        cur_col_reg, cur_col_next;
    logic [ROW_W-1:0]        cur_row_reg, cur_row_next;
    logic [IDX_W-1:0]        cur_idx_reg, cur_idx_next;
    logic [2:0]              nb_reg, nb_next;
    logic [COL_W-1:0]        n_col_reg, n_col_next;
    logic [ROW_W-1:0]        n_row_reg, n_row_next;
    logic [IDX_W-1:0]        n_idx_reg, n_idx_next;

    logic [COL_W-1:0]        min_col_reg, min_col_next, max_col_reg, max_col_next;
    logic [ROW_W-1:0]        min_row_reg, min_row_next, max_row_reg, max_row_next;
    logic [POS_W-1:0]        count_reg, count_next;
    logic                    found_reg, found_next;

    logic                    out_valid_reg, out_valid_next;
    ccb_pkg::out_item_t      out_data_reg, out_data_next;

    logic [DIM_W-1:0]        w_eff;
    logic [HGT_W-1:0]        h_eff;
    logic                    in_acc;
    logic [DIM_W:0]          trial;
    logic                    ge;
    ccb_pkg::nb_dir_t        dir;
    logic                    nb_ok;
    logic [POS_W-1:0]        n_sum;
    logic [ROW_W+DIM_W:0]    mul_sum;
    logic                    scan_hit;
    logic                    nb_hit;

    assign in_ready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign in_acc    = in_valid && in_ready;

    // Geometry in use, clamped to the store.
    always_comb
    begin
        if (width_reg == '0)
            w_eff = DIM_W'(1);
        else if (int'(width_reg) > ccb_pkg::MAX_WIDTH)
            w_eff = DIM_W'(ccb_pkg::MAX_WIDTH);
        else
            w_eff = DIM_W'(width_reg);
        if (height_reg == '0)
            h_eff = HGT_W'(1);
        else if (int'(height_reg) > ccb_pkg::MAX_HEIGHT)
            h_eff = HGT_W'(ccb_pkg::MAX_HEIGHT);
        else
            h_eff = HGT_W'(height_reg);
    end

    // Pixel memory: at most one write and one registered read each cycle.
    always_ff @(posedge clk)
    begin
        if (pm_we)
            pix_mem[pm_waddr] <= pm_wdata;
        pm_q <= pix_mem[pm_raddr];
    end

    // Stack memory.
    always_ff @(posedge clk)
    begin
        if (stk_we)
            stk_mem[stk_waddr] <= stk_wdata;
        stk_q <= stk_mem[stk_raddr];
    end

    // Working datapath values shared by the states below.
    always_comb
    begin
        trial    = {rem_reg, dvd_reg[POS_W-1]};
        ge       = (trial >= {1'b0, w_eff});
        dir      = ccb_pkg::nb_dir(nb_reg);
        nb_ok    = !(dir.left && cur_col_reg == '0)
                && !(dir.up && cur_row_reg == '0)
                && !(dir.right && (DIM_W'(cur_col_reg) + DIM_W'(1)) == w_eff)
                && !(dir.down && (HGT_W'(cur_row_reg) + HGT_W'(1)) == h_eff);
        n_sum    = POS_W'(cur_idx_reg)
                 + (dir.down  ? POS_W'(w_eff) : '0)
                 - (dir.up    ? POS_W'(w_eff) : '0)
                 + (dir.right ? POS_W'(1) : '0)
                 - (dir.left  ? POS_W'(1) : '0);
        mul_sum  = (ROW_W+DIM_W+1)'(stk_q.row * w_eff) + (ROW_W+DIM_W+1)'(stk_q.col);
        scan_hit = pm_q[1] && !pm_q[0];
        nb_hit   = pm_q[1] && !pm_q[0];
    end

    // Sequencer: clearing, pixel writes, divide, scan, flood fill and result hand-off.
    always_comb
    begin
        state_next    = state_reg;
        dirty_next    = dirty_reg;
        clr_next      = clr_reg;
        scan_pos_next = scan_pos_reg;
        scan_col_next = scan_col_reg;
        scan_row_next = scan_row_reg;
        dvd_next      = dvd_reg;
        rem_next      = rem_reg;
        quo_next      = quo_reg;
        dcnt_next     = dcnt_reg;
        lvl_next      = lvl_reg;
        cur_col_next  = cur_col_reg;
        cur_row_next  = cur_row_reg;
        cur_idx_next  = cur_idx_reg;
        nb_next       = nb_reg;
        n_col_next    = n_col_reg;
        n_row_next    = n_row_reg;
        n_idx_next    = n_idx_reg;
        min_col_next  = min_col_reg;
        max_col_next  = max_col_reg;
        min_row_next  = min_row_reg;
        max_row_next  = max_row_reg;
        count_next    = count_reg;
        found_next    = found_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        pm_we     = 1'b0;
        pm_waddr  = scan_pos_reg[IDX_W-1:0];
        pm_wdata  = 2'b11;
        pm_raddr  = scan_pos_reg[IDX_W-1:0];
        stk_we    = 1'b0;
        stk_waddr = lvl_reg[IDX_W-1:0];
        stk_wdata = '{row: scan_row_reg, col: scan_col_reg};
        stk_raddr = lvl_reg[IDX_W-1:0] - IDX_W'(1);

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        // Any geometry change invalidates the cached scan coordinates.
        if (cfg_valid)
            dirty_next = 1'b1;

        unique case (state_reg)
            ST_CLEAR:
            begin
                pm_we    = 1'b1;
                pm_waddr = clr_reg;
                pm_wdata = 2'b00;
                clr_next = clr_reg + IDX_W'(1);
                if (clr_reg == IDX_W'(DEPTH - 1))
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    if (in_data.op == ccb_pkg::OP_WRITE)
                    begin
                        if (int'(in_data.pixel_index) < DEPTH)
                        begin
                            pm_we    = 1'b1;
                            pm_waddr = IDX_W'(in_data.pixel_index);
                            pm_wdata = {in_data.pixel_set, 1'b0};
                        end
                        scan_pos_next = '0;
                        scan_col_next = '0;
                        scan_row_next = '0;
                        dirty_next    = 1'b0;
                    end
                    else if (dirty_reg)
                    begin
                        dvd_next   = scan_pos_reg;
                        rem_next   = '0;
                        quo_next   = '0;
                        dcnt_next  = '0;
                        state_next = ST_DIV;
                    end
                    else
                    begin
                        state_next = ST_SRD;
                    end
                end
            end
            ST_DIV:
            begin
                // One quotient bit a cycle: scan position into row and column.
                rem_next  = ge ? DIM_W'(trial - {1'b0, w_eff}) : DIM_W'(trial);
                quo_next  = {quo_reg[POS_W-2:0], ge};
                dvd_next  = {dvd_reg[POS_W-2:0], 1'b0};
                dcnt_next = dcnt_reg + DCNT_W'(1);
                if (dcnt_reg == DCNT_W'(POS_W - 1))
                begin
                    scan_col_next = COL_W'(rem_next);
                    scan_row_next = ROW_W'(quo_next);
                    dirty_next    = 1'b0;
                    state_next    = ST_SRD;
                end
            end
            ST_SRD:
            begin
                if (scan_pos_reg >= total_reg)
                begin
                    found_next = 1'b0;
                    state_next = ST_DONE;
                end
                else
                begin
                    pm_raddr   = scan_pos_reg[IDX_W-1:0];
                    state_next = ST_SCHK;
                end
            end
            ST_SCHK:
            begin
                if (scan_hit)
                begin
                    pm_we        = 1'b1;
                    pm_waddr     = scan_pos_reg[IDX_W-1:0];
                    pm_wdata     = 2'b11;
                    stk_we       = 1'b1;
                    stk_waddr    = '0;
                    stk_wdata    = '{row: scan_row_reg, col: scan_col_reg};
                    lvl_next     = POS_W'(1);
                    min_col_next = '1;
                    min_row_next = '1;
                    max_col_next = '0;
                    max_row_next = '0;
                    count_next   = '0;
                    found_next   = 1'b1;
                    state_next   = ST_POP;
                end
                else
                begin
                    state_next = ST_SRD;
                end
                // Step the scan by one pixel in raster order.
                scan_pos_next = scan_pos_reg + POS_W'(1);
                if ((DIM_W'(scan_col_reg) + DIM_W'(1)) == w_eff)
                begin
                    scan_col_next = '0;
                    scan_row_next = scan_row_reg + ROW_W'(1);
                end
                else
                begin
                    scan_col_next = scan_col_reg + COL_W'(1);
                end
            end
            ST_POP:
            begin
                if (lvl_reg == '0)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    stk_raddr  = lvl_reg[IDX_W-1:0] - IDX_W'(1);
                    lvl_next   = lvl_reg - POS_W'(1);
                    state_next = ST_PIX;
                end
            end
            ST_PIX:
            begin
                cur_col_next = stk_q.col;
                cur_row_next = stk_q.row;
                cur_idx_next = IDX_W'(mul_sum);
                count_next   = count_reg + POS_W'(1);
                if (stk_q.col < min_col_reg)
                    min_col_next = stk_q.col;
                if (stk_q.col > max_col_reg)
                    max_col_next = stk_q.col;
                if (stk_q.row < min_row_reg)
                    min_row_next = stk_q.row;
                if (stk_q.row > max_row_reg)
                    max_row_next = stk_q.row;
                nb_next    = '0;
                state_next = ST_NRD;
            end
            ST_NRD:
            begin
                if (nb_ok)
                begin
                    pm_raddr   = IDX_W'(n_sum);
                    n_idx_next = IDX_W'(n_sum);
                    n_col_next = dir.right ? cur_col_reg + COL_W'(1)
                               : dir.left ? cur_col_reg - COL_W'(1) : cur_col_reg;
                    n_row_next = dir.down ? cur_row_reg + ROW_W'(1)
                               : dir.up ? cur_row_reg - ROW_W'(1) : cur_row_reg;
                    state_next = ST_NCHK;
                end
                else if (nb_reg == 3'd7)
                begin
                    state_next = ST_POP;
                end
                else
                begin
                    nb_next = nb_reg + 3'd1;
                end
            end
            ST_NCHK:
            begin
                if (nb_hit)
                begin
                    pm_we     = 1'b1;
                    pm_waddr  = n_idx_reg;
                    pm_wdata  = 2'b11;
                    stk_we    = 1'b1;
                    stk_waddr = lvl_reg[IDX_W-1:0];
                    stk_wdata = '{row: n_row_reg, col: n_col_reg};
                    lvl_next  = lvl_reg + POS_W'(1);
                end
                if (nb_reg == 3'd7)
                begin
                    state_next = ST_POP;
                end
                else
                begin
                    nb_next    = nb_reg + 3'd1;
                    state_next = ST_NRD;
                end
            end
            ST_DONE:
            begin
                // Hand the result to the output register once it is free.
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next.found = found_reg;
                    if (found_reg)
                    begin
                        out_data_next.min_col     = 9'(min_col_reg);
                        out_data_next.min_row     = 9'(min_row_reg);
                        out_data_next.max_col     = 9'(max_col_reg);
                        out_data_next.max_row     = 9'(max_row_reg);
                        out_data_next.pixel_count = 19'(count_reg);
                    end
                    else
                    begin
                        out_data_next.min_col     = '0;
                        out_data_next.min_row     = '0;
                        out_data_next.max_col     = '0;
                        out_data_next.max_row     = '0;
                        out_data_next.pixel_count = '0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            width_reg     <= CFG_W_L'(512);
            height_reg    <= CFG_W_L'(512);
            dirty_reg     <= 1'b0;
            total_reg     <= POS_W'(DEPTH);
            scan_pos_reg  <= '0;
            scan_col_reg  <= '0;
            scan_row_reg  <= '0;
            lvl_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            dirty_reg     <= dirty_next;
            total_reg     <= POS_W'(w_eff * h_eff);
            scan_pos_reg  <= scan_pos_next;
            scan_col_reg  <= scan_col_next;
            scan_row_reg  <= scan_row_next;
            lvl_reg       <= lvl_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_index == ccb_pkg::CFG_IMAGE_WIDTH)
                width_reg <= cfg_data;
            if (cfg_valid && cfg_index == ccb_pkg::CFG_IMAGE_HEIGHT)
                height_reg <= cfg_data;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        dvd_reg      <= dvd_next;
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        dcnt_reg     <= dcnt_next;
        cur_col_reg  <= cur_col_next;
        cur_row_reg  <= cur_row_next;
        cur_idx_reg  <= cur_idx_next;
        nb_reg       <= nb_next;
        n_col_reg    <= n_col_next;
        n_row_reg    <= n_row_next;
        n_idx_reg    <= n_idx_next;
        min_col_reg  <= min_col_next;
        max_col_reg  <= max_col_next;
        min_row_reg  <= min_row_next;
        max_row_reg  <= max_row_next;
        count_reg    <= count_next;
        found_reg    <= found_next;
        out_data_reg <= out_data_next;
    end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int SETTLE_CYCLES = 8;
    localparam int END_CYCLES    = 100;
    localparam int HOLD_CYCLES   = 1500;
    localparam int TIMEOUT_NS    = 20000000;
    // Directed image, 4 x 3, raster order: a diagonal pair and a short column.
    localparam logic [11:0] DIRECTED_MASK = 12'h8A1;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    ccb_pkg::in_item_t  in_data;
    logic      out_valid;
    logic      out_ready;
    ccb_pkg::out_item_t out_data;
    logic      cfg_valid;
    logic      cfg_ready;
    logic [ccb_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [ccb_pkg::CFG_W-1:0]     cfg_data;

    // Mirror of the block's image state, kept up to date at each accepted item.
    bit          mask_copy    [ccb_pkg::DEPTH];
    bit          visited_copy [ccb_pkg::DEPTH];
    bit          pixel_written[ccb_pkg::DEPTH];
    int          scan_next;
    logic [9:0]  width_copy;
    logic [9:0]  height_copy;

    ccb_pkg::out_item_t expected_boxes[$];

    int send_idle_pct;
    int stall_pct;
    int hold_req;
    int mismatches;
    int items_sent;
    int pixel_writes;
    int fetches_sent;
    int boxes_found;
    int results_seen;

    connected_component_boxes u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // Dimension in use: the register value clamped to 1..limit.
    function automatic int used_dim(input logic [9:0] raw, input int limit);
        if (raw == 0)
            return 1;
        if (raw > limit)
            return limit;
        return raw;
    endfunction

    function automatic int image_pixels();
        return used_dim(width_copy, ccb_pkg::MAX_WIDTH)
             * used_dim(height_copy, ccb_pkg::MAX_HEIGHT);
    endfunction

    // Resume the raster scan and flood the 8-connected component found there.
    function automatic ccb_pkg::out_item_t next_component_box();
        int w;
        int h;
        int total;
        int start;
        int pos;
        int p;
        int px;
        int py;
        int nx;
        int ny;
        int n;
        int dx;
        int dy;
        int lo_c;
        int lo_r;
        int hi_c;
        int hi_r;
        int area;
        int pending[$];
        ccb_pkg::out_item_t box;
        w     = used_dim(width_copy, ccb_pkg::MAX_WIDTH);
        h     = used_dim(height_copy, ccb_pkg::MAX_HEIGHT);
        total = w * h;
        start = total;
        box   = '0;
        for (pos = scan_next; pos < total; pos++)
        begin
            if (mask_copy[pos] && !visited_copy[pos])
            begin
                start = pos;
                break;
            end
        end
        if (start >= total)
        begin
            if (scan_next < total)
                scan_next = total;
            return box;
        end
        scan_next = start + 1;
        lo_c = start % w;
        hi_c = lo_c;
        lo_r = start / w;
        hi_r = lo_r;
        area = 0;
        visited_copy[start] = 1'b1;
        pending.insert(pending.size(), start);
        while (pending.size() > 0)
        begin
            p  = pending[pending.size() - 1];
            pending.delete(pending.size() - 1);
            px = p % w;
            py = p / w;
            area++;
            if (px < lo_c) lo_c = px;
            if (px > hi_c) hi_c = px;
            if (py < lo_r) lo_r = py;
            if (py > hi_r) hi_r = py;
            for (dy = -1; dy <= 1; dy++)
            begin
                for (dx = -1; dx <= 1; dx++)
                begin
                    nx = px + dx;
                    ny = py + dy;
                    if ((dx == 0 && dy == 0) || nx < 0 || ny < 0 || nx >= w || ny >= h)
                        continue;
                    n = ny * w + nx;
                    if (mask_copy[n] && !visited_copy[n])
                    begin
                        visited_copy[n] = 1'b1;
                        pending.insert(pending.size(), n);
                    end
                end
            end
        end
        box.found       = 1'b1;
        box.min_col     = lo_c[8:0];
        box.min_row     = lo_r[8:0];
        box.max_col     = hi_c[8:0];
        box.max_row     = hi_r[8:0];
        box.pixel_count = area[18:0];
        return box;
    endfunction

    // Offer one item, hold it until accepted, then update the mirror.
    task automatic send_pixel_op(input logic op, input int idx, input logic set,
                                 output logic found);
        ccb_pkg::in_item_t  item;
        ccb_pkg::out_item_t box;
        item.op          = op;
        item.pixel_index = idx[17:0];
        item.pixel_set   = set;
        found            = 1'b0;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (in_ready !== 1'b1)
            @(posedge clk);
        items_sent++;
        if (op == ccb_pkg::OP_WRITE)
        begin
            pixel_writes++;
            mask_copy[item.pixel_index]     = set;
            visited_copy[item.pixel_index]  = 1'b0;
            pixel_written[item.pixel_index] = 1'b1;
            scan_next = 0;
        end
        else
        begin
            fetches_sent++;
            box = next_component_box();
            expected_boxes.insert(expected_boxes.size(), box);
            found = box.found;
            if (box.found)
                boxes_found++;
        end
    endtask

    task automatic write_pixel(input int idx, input logic set);
        logic unused;
        send_pixel_op(ccb_pkg::OP_WRITE, idx, set, unused);
    endtask

    task automatic fetch_component(output logic found);
        send_pixel_op(ccb_pkg::OP_FETCH, 0, 1'b0, found);
    endtask

    // Fetch until the scan reports no component left, then a few more.
    task automatic drain_components(input int extra);
        logic more;
        int   i;
        fetch_component(more);
        while (more)
            fetch_component(more);
        for (i = 0; i < extra; i++)
            fetch_component(more);
    endtask

    // Stop offering, wait for every result, then let a pending write finish.
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_boxes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [ccb_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [ccb_pkg::CFG_W-1:0] value);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (cfg_ready !== 1'b1)
            @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == ccb_pkg::CFG_IMAGE_WIDTH)
            width_copy = value;
        else
            height_copy = value;
    endtask

    task automatic set_geometry(input logic [9:0] w, input logic [9:0] h);
        write_register(ccb_pkg::CFG_IMAGE_WIDTH, w);
        write_register(ccb_pkg::CFG_IMAGE_HEIGHT, h);
    endtask

    // Write every pixel of the image in use that has never been written.
    task automatic cover_image(input int density);
        int i;
        int total;
        total = image_pixels();
        for (i = 0; i < total; i++)
        begin
            if (!pixel_written[i])
                write_pixel(i, $urandom_range(0, 99) < density);
        end
    endtask

    task automatic set_idling(input int sender, input int receiver);
        send_idle_pct = sender;
        stall_pct     = receiver;
    endtask

    // Small hand-built image: diagonal joins, repeated empty fetches,
    // a write restarting the scan, geometry changed in the middle of a scan.
    task automatic test_directed();
        logic f;
        int   i;
        set_idling(0, 0);
        set_geometry(10'd4, 10'd3);
        for (i = 0; i < 12; i++)
            write_pixel(i, DIRECTED_MASK[i]);
        drain_components(1);
        // Extreme index outside the image: the scan restarts, nothing new is found.
        write_pixel(ccb_pkg::DEPTH - 1, 1'b1);
        fetch_component(f);
        // A fresh pixel beside visited ones comes out on its own.
        write_pixel(2, 1'b1);
        fetch_component(f);
        set_geometry(10'd2, 10'd3);
        fetch_component(f);
        // Zero registers clamp to a single pixel, which lies behind the scan.
        set_geometry(10'd0, 10'd0);
        fetch_component(f);
        set_geometry(10'd4, 10'd3);
        write_pixel(5, 1'b1);
        fetch_component(f);
        fetch_component(f);
    endtask

    // Single-row and single-column images at the largest size, with clamping.
    task automatic test_geometry_extremes();
        int i;
        set_idling(20, 20);
        set_geometry(10'd1023, 10'd1);
        cover_image(85);
        drain_components(1);
        set_geometry(10'd1, 10'd1023);
        for (i = 0; i < 60; i++)
            write_pixel($urandom_range(0, 511), $urandom_range(0, 99) < 70);
        drain_components(1);
        set_geometry(10'd512, 10'd1);
        for (i = 0; i < 40; i++)
            write_pixel($urandom_range(0, 511), $urandom_range(0, 99) < 95);
        drain_components(0);
        set_geometry(10'd1, 10'd1);
        write_pixel(0, 1'b1);
        drain_components(1);
    endtask

    // The receiver holds off while fetches keep coming, then the sender
    // pauses until every result is back.
    task automatic test_backpressure();
        int i;
        set_idling(0, 0);
        set_geometry(10'd16, 10'd8);
        cover_image(30);
        for (i = 0; i < 60; i++)
            write_pixel($urandom_range(0, 127), $urandom_range(0, 99) < 30);
        hold_req = HOLD_CYCLES;
        drain_components(3);
        wait_idle();
        drain_components(1);
    endtask

    // Random images: rewrite part of the mask, sometimes with stray writes
    // and early fetches, then read out every component.
    task automatic test_random_images(input int sender, input int receiver,
                                      input int budget);
        int   stop_at;
        int   w;
        int   h;
        int   density;
        int   edits;
        int   i;
        int   roll;
        logic f;
        set_idling(sender, receiver);
        stop_at = items_sent + budget;
        while (items_sent < stop_at)
        begin
            if ($urandom_range(0, 3) != 0)
            begin
                w = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 64) : $urandom_range(1, 24);
                h = $urandom_range(1, (512 / w < 20) ? 512 / w : 20);
                if ($urandom_range(0, 9) == 0)
                    w = 0;
                set_geometry(w[9:0], h[9:0]);
            end
            case ($urandom_range(0, 4))
                0:       density = 5;
                1:       density = 25;
                2:       density = 50;
                3:       density = 75;
                default: density = 100;
            endcase
            cover_image(density);
            edits = $urandom_range(0, 48);
            for (i = 0; i < edits; i++)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 90)
                    write_pixel($urandom_range(0, image_pixels() - 1),
                                $urandom_range(0, 99) < density);
                else if (roll < 95)
                    write_pixel($urandom_range(0, ccb_pkg::DEPTH - 1),
                                1'($urandom_range(0, 1)));
                else
                    fetch_component(f);
            end
            drain_components($urandom_range(0, 2));
        end
    endtask

    // Output side: random stalls, and a long hold-off whenever one is requested.
    initial
    begin
        int n;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req > 0)
            begin
                n        = hold_req;
                hold_req = 0;
                out_ready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            out_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    task automatic flag_mismatch(input string field, input logic [18:0] want,
                                 input logic [18:0] got);
        $display("%0t ns: %s expected %0h, got %0h", $time, field, want, got);
        mismatches++;
    endtask

    // Each result is matched against the oldest outstanding prediction.
    always @(posedge clk)
    begin : result_check
        ccb_pkg::out_item_t want;
        if (out_valid === 1'b1 && out_ready === 1'b1)
        begin
            results_seen++;
            if (expected_boxes.size() == 0)
            begin
                $display("%0t ns: unexpected result, expected none, got %0h", $time, out_data);
                mismatches++;
            end
            else
            begin
                want = expected_boxes.pop_front();
                if (out_data.found !== want.found)
                    flag_mismatch("found", want.found, out_data.found);
                if (out_data.min_col !== want.min_col)
                    flag_mismatch("min_col", want.min_col, out_data.min_col);
                if (out_data.min_row !== want.min_row)
                    flag_mismatch("min_row", want.min_row, out_data.min_row);
                if (out_data.max_col !== want.max_col)
                    flag_mismatch("max_col", want.max_col, out_data.max_col);
                if (out_data.max_row !== want.max_row)
                    flag_mismatch("max_row", want.max_row, out_data.max_row);
                if (out_data.pixel_count !== want.pixel_count)
                    flag_mismatch("pixel_count", want.pixel_count, out_data.pixel_count);
            end
        end
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("timeout with %0d results outstanding", expected_boxes.size());
        $display("status: fail");
        $finish;
    end

    initial
    begin
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_data   <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        width_copy    = 10'd512;
        height_copy   = 10'd512;
        scan_next     = 0;
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_req      = 0;
        mismatches    = 0;
        items_sent    = 0;
        pixel_writes  = 0;
        fetches_sent  = 0;
        boxes_found   = 0;
        results_seen  = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_geometry_extremes();
        test_backpressure();
        test_random_images(0, 0, 90);
        test_random_images(81, 0, 90);
        test_random_images(0, 81, 90);
        test_random_images(20, 20, 90);

        wait_idle();
        repeat (END_CYCLES) @(posedge clk);
        $display("%0d items sent: %0d pixel writes, %0d fetches; %0d results checked",
                 items_sent, pixel_writes, fetches_sent, results_seen);
        $display("%0d components returned over images from 1x1 up to 512x1 and 1x512",
                 boxes_found);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
